FILE: rtl/core/tet_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tracked entity table package
// Command and status codes and the sequencer state type.
// ----------------------------------------------------------------------------
package tet_pkg;

  localparam logic [1:0] CMD_REPORT = 2'd0;
  localparam logic [1:0] CMD_OWNSHIP = 2'd1;
  localparam logic [1:0] CMD_READ = 2'd2;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  localparam logic [3:0] ST_IGNORED = 4'd0;
  localparam logic [3:0] ST_UPDATED = 4'd1;
  localparam logic [3:0] ST_ADDED = 4'd2;
  localparam logic [3:0] ST_REMOVED = 4'd3;
  localparam logic [3:0] ST_FULL = 4'd4;
  localparam logic [3:0] ST_READ_OK = 4'd5;
  localparam logic [3:0] ST_BAD_INDEX = 4'd6;
  localparam logic [3:0] ST_OWN_SET = 4'd7;
  localparam logic [3:0] ST_OWN_SWEPT = 4'd8;

  localparam logic [0:0] CFG_TIMEOUT = 1'd0;
  localparam logic [0:0] CFG_INTERVAL = 1'd1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SEARCH_RD,
    S_SEARCH_CHK,
    S_MOVE_RD,
    S_MOVE_WR,
    S_SWEEP_RD,
    S_SWEEP_CHK,
    S_READ_RD,
    S_READ_DONE,
    S_OUT
  } state_e;

endpackage

FILE: rtl/core/tracked_entity_table_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tracked entity table
// Compact table of tracked vehicles held in one synchronous memory.
// ----------------------------------------------------------------------------
// The table keeps up to MAX_ENTRIES vehicles (entry 0 is the own vehicle) in a
// single memory of id, payload and time, with one registered read port. Items
// are handled one at a time by a sequencer. A report walks the table entry by
// entry to look for its id, then writes or moves one entry. An ownship item
// that sweeps checks every entry, and each removal that moves an entry reads
// the last entry and copies it into the freed slot. The result is held in an
// output register until taken, and the next item is accepted once the result
// has left. There is no clearing pass: only entries below the fill count are
// ever read, and entry 0 resets via a flag.
module tracked_entity_table_top #(
  parameter int MAX_ENTRIES = 32,
  parameter int PAYLOAD_BITS = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  command_i,
  input  logic [31:0] track_id_i,
  input  logic        location_valid_i,
  input  logic [63:0] vehicle_payload_i,
  input  logic [31:0] now_ms_i,
  input  logic [4:0]  read_index_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [3:0]  status_o,
  output logic [5:0]  entry_count_o,
  output logic [4:0]  entry_position_o,
  output logic [31:0] entry_id_o,
  output logic [63:0] entry_payload_o,
  output logic [31:0] entry_time_o
);

  localparam int AW = $clog2(MAX_ENTRIES);
  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int EW = 64 + PAYLOAD_BITS;

  typedef struct packed {
    logic [31:0]             id;
    logic [PAYLOAD_BITS-1:0] pay;
    logic [31:0]             tm;
  } entry_t;

  // Entry memory.
  entry_t mem_q [MAX_ENTRIES];
  entry_t rd_q;
  logic [AW-1:0] raddr;
  logic [AW-1:0] waddr;
  entry_t wdata;
  logic we;
  logic own_wr_q;   // entry 0 has been written since reset

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    rd_q <= mem_q[raddr];
  end

  // Entry 0 reads as zero until first written.
  logic rd0_q;
  entry_t rd;
  assign rd = (rd0_q && !own_wr_q) ? entry_t'({EW{1'b0}}) : rd_q;

  // Configuration.
  logic [31:0] timeout_q;
  logic [15:0] interval_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= 32'd10000;
      interval_q <= 16'd1000;
    end else if (cfg_we_i) begin
      if (cfg_index_i == tet_pkg::CFG_TIMEOUT) begin
        timeout_q <= cfg_data_i;
      end else begin
        interval_q <= cfg_data_i[15:0];
      end
    end
  end

  // Control state. The walk index is as wide as the count so that it can
  // step past the last entry of a full table.
  tet_pkg::state_e state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] idx_q, idx_d;
  logic [31:0] last_sweep_q, last_sweep_d;
  logic own_wr_d;

  // Latched item.
  logic [1:0] cmd_q;
  logic [31:0] vid_q;
  logic loc_q;
  logic [PAYLOAD_BITS-1:0] pay_q;
  logic [31:0] now_q;
  logic [31:0] own_id_q;   // copy of entry 0's id

  // Result register.
  logic [3:0] st_q, st_d;
  logic [4:0] pos_q, pos_d;
  entry_t res_q, res_d;
  logic res_ld;

  logic accept;
  assign accept = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != tet_pkg::S_IDLE);

  logic [CW-1:0] last_idx;
  assign last_idx = count_q - CW'(1);
  logic stale;
  assign stale = (now_q - rd.tm) > timeout_q;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      tet_pkg::S_IDLE: begin
        if (accept) begin
          if (command_i == tet_pkg::CMD_REPORT) begin
            state_d = (track_id_i == own_id_q) ? tet_pkg::S_OUT : tet_pkg::S_SEARCH_RD;
          end else if (command_i == tet_pkg::CMD_OWNSHIP) begin
            state_d = ((now_ms_i - last_sweep_q) < {16'd0, interval_q}) ?
                      tet_pkg::S_OUT : tet_pkg::S_SWEEP_RD;
          end else if (command_i == tet_pkg::CMD_READ) begin
            state_d = ({1'b0, read_index_i} < 6'(count_q) && 32'(read_index_i) < MAX_ENTRIES)
                      ? tet_pkg::S_READ_RD : tet_pkg::S_OUT;
          end else begin
            state_d = tet_pkg::S_OUT;
          end
        end
      end
      tet_pkg::S_SEARCH_RD: begin
        state_d = (idx_q >= count_q) ? tet_pkg::S_OUT : tet_pkg::S_SEARCH_CHK;
      end
      tet_pkg::S_SEARCH_CHK: begin
        if (rd.id == vid_q) begin
          state_d = (!loc_q && idx_q != last_idx) ? tet_pkg::S_MOVE_RD : tet_pkg::S_OUT;
        end else begin
          state_d = tet_pkg::S_SEARCH_RD;
        end
      end
      tet_pkg::S_MOVE_RD: state_d = tet_pkg::S_MOVE_WR;
      tet_pkg::S_MOVE_WR: begin
        state_d = (cmd_q == tet_pkg::CMD_OWNSHIP) ? tet_pkg::S_SWEEP_RD : tet_pkg::S_OUT;
      end
      tet_pkg::S_SWEEP_RD: begin
        state_d = (idx_q >= count_q) ? tet_pkg::S_OUT : tet_pkg::S_SWEEP_CHK;
      end
      tet_pkg::S_SWEEP_CHK: begin
        if (stale && idx_q != last_idx) begin
          state_d = tet_pkg::S_MOVE_RD;
        end else begin
          state_d = tet_pkg::S_SWEEP_RD;
        end
      end
      tet_pkg::S_READ_RD: state_d = tet_pkg::S_READ_DONE;
      tet_pkg::S_READ_DONE: state_d = tet_pkg::S_OUT;
      tet_pkg::S_OUT: begin
        if (!out_stall_i) begin
          state_d = tet_pkg::S_IDLE;
        end
      end
      default: state_d = tet_pkg::S_IDLE;
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    count_d = count_q;
    idx_d = idx_q;
    last_sweep_d = last_sweep_q;
    own_wr_d = own_wr_q;
    st_d = st_q;
    pos_d = pos_q;
    res_d = res_q;
    res_ld = 1'b0;
    raddr = idx_q[AW-1:0];
    waddr = idx_q[AW-1:0];
    wdata = '{id: vid_q, pay: pay_q, tm: now_q};
    we = 1'b0;
    case (state_q)
      tet_pkg::S_IDLE: begin
        if (accept) begin
          res_ld = 1'b1;
          st_d = tet_pkg::ST_IGNORED;
          pos_d = '0;
          res_d = entry_t'({EW{1'b0}});
          idx_d = CW'(1);
          if (command_i == tet_pkg::CMD_OWNSHIP) begin
            we = 1'b1;
            waddr = '0;
            wdata = '{id: track_id_i, pay: vehicle_payload_i[PAYLOAD_BITS-1:0],
                      tm: now_ms_i};
            own_wr_d = 1'b1;
            idx_d = '0;
            if ((now_ms_i - last_sweep_q) < {16'd0, interval_q}) begin
              st_d = tet_pkg::ST_OWN_SET;
            end else begin
              st_d = tet_pkg::ST_OWN_SWEPT;
              last_sweep_d = now_ms_i;
            end
          end else if (command_i == tet_pkg::CMD_READ) begin
            if ({1'b0, read_index_i} < 6'(count_q) && 32'(read_index_i) < MAX_ENTRIES) begin
              idx_d = CW'(read_index_i);
            end else begin
              st_d = tet_pkg::ST_BAD_INDEX;
            end
          end
        end
      end
      tet_pkg::S_SEARCH_RD: begin
        if (idx_q >= count_q) begin
          if (loc_q) begin
            if (count_q < CW'(MAX_ENTRIES)) begin
              we = 1'b1;
              waddr = count_q[AW-1:0];
              count_d = count_q + CW'(1);
              st_d = tet_pkg::ST_ADDED;
              pos_d = 5'(count_q);
            end else begin
              st_d = tet_pkg::ST_FULL;
            end
          end
        end
      end
      tet_pkg::S_SEARCH_CHK: begin
        if (rd.id == vid_q) begin
          pos_d = 5'(idx_q);
          if (loc_q) begin
            we = 1'b1;
            st_d = tet_pkg::ST_UPDATED;
          end else begin
            st_d = tet_pkg::ST_REMOVED;
            if (idx_q == last_idx) begin
              count_d = count_q - CW'(1);
            end
          end
        end else begin
          idx_d = idx_q + CW'(1);
        end
      end
      tet_pkg::S_MOVE_RD: begin
        raddr = last_idx[AW-1:0];
        count_d = count_q - CW'(1);
      end
      tet_pkg::S_MOVE_WR: begin
        we = 1'b1;
        wdata = rd;
      end
      tet_pkg::S_SWEEP_CHK: begin
        if (stale) begin
          if (idx_q == last_idx) begin
            count_d = count_q - CW'(1);
          end
        end else begin
          idx_d = idx_q + CW'(1);
        end
      end
      tet_pkg::S_READ_DONE: begin
        res_ld = 1'b1;
        st_d = tet_pkg::ST_READ_OK;
        pos_d = 5'(idx_q);
        res_d = rd;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tet_pkg::S_IDLE;
      count_q <= CW'(1);
      idx_q <= '0;
      last_sweep_q <= '0;
      own_wr_q <= 1'b0;
      own_id_q <= '0;
      rd0_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      idx_q <= idx_d;
      last_sweep_q <= last_sweep_d;
      own_wr_q <= own_wr_d;
      rd0_q <= (raddr == '0);
      if (accept && command_i == tet_pkg::CMD_OWNSHIP) begin
        own_id_q <= track_id_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= command_i;
      vid_q <= track_id_i;
      loc_q <= location_valid_i;
      pay_q <= vehicle_payload_i[PAYLOAD_BITS-1:0];
      now_q <= now_ms_i;
    end
    st_q <= st_d;
    pos_q <= pos_d;
    if (res_ld) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = (state_q == tet_pkg::S_OUT);
  assign status_o = st_q;
  assign entry_count_o = 6'(count_q);
  assign entry_position_o = pos_q;
  assign entry_id_o = res_q.id;
  assign entry_payload_o = 64'(res_q.pay);
  assign entry_time_o = res_q.tm;

endmodule

FILE: bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tracked entity table testbench
// Drives reports, ownship updates and reads through the valid/stall ports
// with random gaps on both sides, predicts every result with a behavioral
// model of the table, and compares each result field by field.
// ----------------------------------------------------------------------------
module testbench;

  localparam int MAX_ENTRIES = 32;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 400;

  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] track_id;
    logic        location_valid;
    logic [63:0] vehicle_payload;
    logic [31:0] now_ms;
    logic [4:0]  read_index;
  } request_t;

  typedef struct packed {
    logic [3:0]  status;
    logic [5:0]  entry_count;
    logic [4:0]  entry_position;
    logic [31:0] entry_id;
    logic [63:0] entry_payload;
    logic [31:0] entry_time;
  } answer_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [0:0]  cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  command_i = '0;
  logic [31:0] track_id_i = '0;
  logic        location_valid_i = 1'b0;
  logic [63:0] vehicle_payload_i = '0;
  logic [31:0] now_ms_i = '0;
  logic [4:0]  read_index_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [3:0]  status_o;
  logic [5:0]  entry_count_o;
  logic [4:0]  entry_position_o;
  logic [31:0] entry_id_o;
  logic [63:0] entry_payload_o;
  logic [31:0] entry_time_o;

  tracked_entity_table_top dut (.*);

  always #2 clk_i = ~clk_i;

  // Shadow copy of the table that the predictor keeps in step with the block.
  logic [31:0] tbl_id [MAX_ENTRIES];
  logic [63:0] tbl_pay [MAX_ENTRIES];
  logic [31:0] tbl_time [MAX_ENTRIES];
  int unsigned tbl_used;
  logic [31:0] last_sweep;
  logic [31:0] timeout_ms;
  logic [15:0] interval_ms;

  request_t pending_items[$];
  answer_t  expected_answers[$];
  int       error_count = 0;
  int       idle_cycles = 0;
  bit       hold_receiver = 1'b0;
  // Known ids of tracked vehicles, used to aim reports at existing entries.
  logic [31:0] id_pool[$];
  logic [31:0] clock_ms;

  // Drops entry pos by moving the last entry into its slot.
  function automatic void remove_entry(int unsigned pos);
    tbl_used--;
    if (pos != tbl_used) begin
      tbl_id[pos] = tbl_id[tbl_used];
      tbl_pay[pos] = tbl_pay[tbl_used];
      tbl_time[pos] = tbl_time[tbl_used];
    end
  endfunction

  function automatic answer_t predict_table(request_t r);
    answer_t a;
    int unsigned found;
    int unsigned i;
    a = '0;
    a.status = tet_pkg::ST_IGNORED;
    if (r.command == tet_pkg::CMD_REPORT) begin
      if (r.track_id != tbl_id[0]) begin
        found = 0;
        for (i = 1; i < tbl_used; i++) begin
          if (found == 0 && tbl_id[i] == r.track_id) found = i;
        end
        if (!r.location_valid) begin
          if (found != 0) begin
            remove_entry(found);
            a.status = tet_pkg::ST_REMOVED;
            a.entry_position = found[4:0];
          end
        end else if (found != 0) begin
          tbl_pay[found] = r.vehicle_payload;
          tbl_time[found] = r.now_ms;
          a.status = tet_pkg::ST_UPDATED;
          a.entry_position = found[4:0];
        end else if (tbl_used < MAX_ENTRIES) begin
          tbl_id[tbl_used] = r.track_id;
          tbl_pay[tbl_used] = r.vehicle_payload;
          tbl_time[tbl_used] = r.now_ms;
          a.status = tet_pkg::ST_ADDED;
          a.entry_position = tbl_used[4:0];
          tbl_used++;
        end else begin
          a.status = tet_pkg::ST_FULL;
        end
      end
    end else if (r.command == tet_pkg::CMD_OWNSHIP) begin
      tbl_id[0] = r.track_id;
      tbl_pay[0] = r.vehicle_payload;
      tbl_time[0] = r.now_ms;
      if (32'(r.now_ms - last_sweep) < {16'd0, interval_ms}) begin
        a.status = tet_pkg::ST_OWN_SET;
      end else begin
        last_sweep = r.now_ms;
        i = 0;
        while (i < tbl_used) begin
          if (32'(r.now_ms - tbl_time[i]) > timeout_ms) remove_entry(i);
          else i++;
        end
        a.status = tet_pkg::ST_OWN_SWEPT;
      end
    end else if (r.command == tet_pkg::CMD_READ) begin
      if (r.read_index < tbl_used) begin
        a.status = tet_pkg::ST_READ_OK;
        a.entry_position = r.read_index;
        a.entry_id = tbl_id[r.read_index];
        a.entry_payload = tbl_pay[r.read_index];
        a.entry_time = tbl_time[r.read_index];
      end else begin
        a.status = tet_pkg::ST_BAD_INDEX;
      end
    end
    a.entry_count = tbl_used[5:0];
    return a;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [31:0] pick_id();
    if (id_pool.size() != 0 && $urandom_range(0, 3) != 0)
      return id_pool[$urandom_range(0, id_pool.size() - 1)];
    return $urandom_range(0, 1) ? $urandom() : 32'($urandom_range(1, 60));
  endfunction

  // Builds one random item. Time mostly advances in small steps so that
  // entries age realistically; now and then it jumps, to cover the wrap.
  function automatic request_t random_item();
    request_t r;
    int unsigned sel;
    r.vehicle_payload = rand64();
    r.read_index = 5'($urandom());
    r.location_valid = ($urandom_range(0, 4) != 0);
    sel = $urandom_range(0, 99);
    if (sel < 3) clock_ms = $urandom();
    else clock_ms = clock_ms + 32'($urandom_range(0, 400));
    r.now_ms = clock_ms;
    r.track_id = pick_id();
    if (sel < 65) begin
      r.command = tet_pkg::CMD_REPORT;
      if (r.location_valid && id_pool.size() < 60) id_pool.push_back(r.track_id);
    end else if (sel < 75) begin
      r.command = tet_pkg::CMD_OWNSHIP;
    end else if (sel < 97) begin
      r.command = tet_pkg::CMD_READ;
    end else begin
      r.command = tet_pkg::CMD_UNUSED;
    end
    return r;
  endfunction

  function automatic request_t make_item(logic [1:0] cmd, logic [31:0] vid, logic loc,
                                         logic [63:0] pay, logic [31:0] now,
                                         logic [4:0] idx);
    request_t r;
    r.command = cmd;
    r.track_id = vid;
    r.location_valid = loc;
    r.vehicle_payload = pay;
    r.now_ms = now;
    r.read_index = idx;
    return r;
  endfunction

  // The acceptance decision below is made at the falling edge from the values
  // that held at the previous rising edge, which is when the block took them.
  logic took_item;
  always @(posedge clk_i) took_item <= in_valid_i && !in_stall_o;

  // Sender: a random gap, drawn per accepted item, comes before the next item is offered.
  // The payload holds while stalled; valid stays high between back-to-back items.
  int send_gap = 0;
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (took_item) begin
        expected_answers.push_back(predict_table(pending_items.pop_front()));
        send_gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 12);
      end
      if (in_valid_i && !took_item) begin
        // hold the item until the block takes it
      end else if (send_gap > 0 || pending_items.size() == 0) begin
        if (send_gap > 0) send_gap--;
        in_valid_i <= 1'b0;
      end else begin
        in_valid_i <= 1'b1;
        command_i <= pending_items[0].command;
        track_id_i <= pending_items[0].track_id;
        location_valid_i <= pending_items[0].location_valid;
        vehicle_payload_i <= pending_items[0].vehicle_payload;
        now_ms_i <= pending_items[0].now_ms;
        read_index_i <= pending_items[0].read_index;
      end
    end
  end

  // Receiver stalls: random per item, or one long hold-off on request.
  int recv_gap = 0;
  always @(negedge clk_i) begin
    if (hold_receiver) begin
      out_stall_i <= 1'b1;
    end else if (recv_gap > 0) begin
      recv_gap--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Monitor: compares each accepted result with the oldest expectation.
  always @(posedge clk_i) begin
    answer_t got;
    answer_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = {status_o, entry_count_o, entry_position_o, entry_id_o,
             entry_payload_o, entry_time_o};
      if (expected_answers.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        error_count++;
      end else begin
        want = expected_answers.pop_front();
        if (got.status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
          error_count++;
        end
        if (got.entry_count !== want.entry_count) begin
          $display("%0t: count expected %0d actual %0d", $time,
                   want.entry_count, got.entry_count);
          error_count++;
        end
        if (got.entry_position !== want.entry_position) begin
          $display("%0t: position expected %0d actual %0d", $time,
                   want.entry_position, got.entry_position);
          error_count++;
        end
        if (got.entry_id !== want.entry_id) begin
          $display("%0t: id expected %h actual %h", $time, want.entry_id, got.entry_id);
          error_count++;
        end
        if (got.entry_payload !== want.entry_payload) begin
          $display("%0t: payload expected %h actual %h", $time,
                   want.entry_payload, got.entry_payload);
          error_count++;
        end
        if (got.entry_time !== want.entry_time) begin
          $display("%0t: time expected %h actual %h", $time,
                   want.entry_time, got.entry_time);
          error_count++;
        end
      end
      recv_gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 12);
    end
  end

  // Watchdog on cycles with no accepted item on either side.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || hold_receiver)
      idle_cycles <= 0;
    else if (pending_items.size() != 0 || expected_answers.size() != 0)
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic write_register(logic [0:0] idx, logic [31:0] value);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == tet_pkg::CFG_TIMEOUT) timeout_ms = value;
    else interval_ms = value[15:0];
  endtask

  task automatic wait_drained();
    while (pending_items.size() != 0 || expected_answers.size() != 0 || in_valid_i)
      @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  initial begin
    int phase;
    int k;
    for (k = 0; k < MAX_ENTRIES; k++) begin
      tbl_id[k] = '0;
      tbl_pay[k] = '0;
      tbl_time[k] = '0;
    end
    tbl_used = 1;
    last_sweep = '0;
    timeout_ms = 32'd10000;
    interval_ms = 16'd1000;
    clock_ms = '0;
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed part, under the reset register values.
    pending_items.push_back(make_item(tet_pkg::CMD_READ, 0, 0, 0, 0, 5'd0));
    pending_items.push_back(make_item(tet_pkg::CMD_READ, 0, 0, 0, 0, 5'd31));
    // Own id reported while ownship is still zero.
    pending_items.push_back(make_item(tet_pkg::CMD_REPORT, 32'd0, 1, rand64(), 32'd5, 0));
    pending_items.push_back(make_item(tet_pkg::CMD_REPORT, 32'hFFFFFFFF, 1, '1, 32'd10, 0));
    pending_items.push_back(make_item(tet_pkg::CMD_REPORT, 32'd7, 1, 64'h1, 32'd20, 0));
    pending_items.push_back(make_item(tet_pkg::CMD_REPORT, 32'd7, 1,
                                      64'h8000_0000_0000_0000, 32'd30, 0));
    // Invalid location for an untracked vehicle changes nothing.
    pending_items.push_back(make_item(tet_pkg::CMD_REPORT, 32'd9, 0, 0, 32'd40, 0));
    pending_items.push_back(make_item(tet_pkg::CMD_READ, 0, 0, 0, 0, 5'd1));
    pending_items.push_back(make_item(tet_pkg::CMD_READ, 0, 0, 0, 0, 5'd2));
    // Removing entry 1 moves the last entry into its slot.
    pending_items.push_back(make_item(tet_pkg::CMD_REPORT, 32'hFFFFFFFF, 0, 0, 32'd50, 0));
    pending_items.push_back(make_item(tet_pkg::CMD_READ, 0, 0, 0, 0, 5'd1));
    // Sweep too soon, then a real sweep, then ownship's id reported.
    pending_items.push_back(make_item(tet_pkg::CMD_OWNSHIP, 32'd42, 1, rand64(), 32'd100, 0));
    pending_items.push_back(make_item(tet_pkg::CMD_OWNSHIP, 32'd42, 1, rand64(),
                                      32'd20000, 0));
    pending_items.push_back(make_item(tet_pkg::CMD_REPORT, 32'd42, 1, rand64(),
                                      32'd20001, 0));
    pending_items.push_back(make_item(tet_pkg::CMD_UNUSED, '1, 1, '1, '1, '1));
    // Wrap of the millisecond clock.
    pending_items.push_back(make_item(tet_pkg::CMD_REPORT, 32'd11, 1, rand64(),
                                      32'hFFFF_FFF0, 0));
    pending_items.push_back(make_item(tet_pkg::CMD_OWNSHIP, 32'd42, 1, rand64(),
                                      32'h0000_0100, 0));
    pending_items.push_back(make_item(tet_pkg::CMD_READ, 0, 0, 0, 0, 5'd1));
    // Fill the table to the brim and beyond.
    for (k = 0; k < MAX_ENTRIES; k++)
      pending_items.push_back(make_item(tet_pkg::CMD_REPORT, 32'd1000 + k, 1, rand64(),
                                        32'h200 + k, 0));
    pending_items.push_back(make_item(tet_pkg::CMD_READ, 0, 0, 0, 0, 5'd31));
    clock_ms = 32'h300;
    wait_drained();

    for (phase = 0; phase < 5; phase++) begin
      case (phase)
        0: begin
          write_register(tet_pkg::CFG_TIMEOUT, 32'd0);
          write_register(tet_pkg::CFG_INTERVAL, 16'd0);
        end
        1: begin
          write_register(tet_pkg::CFG_TIMEOUT, 32'hFFFF_FFFF);
          write_register(tet_pkg::CFG_INTERVAL, 16'hFFFF);
        end
        default: begin
          write_register(tet_pkg::CFG_TIMEOUT, $urandom_range(200, 6000));
          write_register(tet_pkg::CFG_INTERVAL, $urandom_range(0, 2000));
        end
      endcase
      id_pool.delete();
      for (k = 0; k < 400; k++) pending_items.push_back(random_item());
      if (phase == 2) begin
        // Long receiver hold-off while items keep coming, to fill the block.
        hold_receiver = 1'b1;
        repeat (300) @(negedge clk_i);
        hold_receiver = 1'b0;
      end
      wait_drained();
    end

    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
